>>> rtl/float_fake_log_quantizer_macros.svh
// assertion helpers included by float_fake_log_quantizer.sv
`ifndef FLOAT_FAKE_LOG_QUANTIZER_MACROS_SVH
`define FLOAT_FAKE_LOG_QUANTIZER_MACROS_SVH

// clocked check, quiet while reset is asserted
`define FFL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// clocked check that also holds during reset
`define FFL_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/ffl_pkg.sv
`default_nettype none
package ffl_pkg;

	// register file layout
	localparam int ADDR_W = 5;
	localparam int DATA_W = 64;

	typedef enum logic [1:0] {
		REG_LOWEST_EXP = 2'd0,
		REG_SCALE      = 2'd1,
		REG_MIXED      = 2'd2
	} reg_idx_t;

	// field widths
	localparam int EXP_W   = 8;
	localparam int MANT_W  = 23;
	localparam int SCALE_W = 55;
	localparam int CODE_W  = 32;

	// datapath widths
	localparam int LG_W  = EXP_W + MANT_W;
	localparam int SLO_W = 24;
	localparam int SHI_W = SCALE_W - SLO_W;
	localparam int PHI_W = LG_W + SHI_W;
	localparam int PLO_W = LG_W + SLO_W;
	localparam int LOW_W = PLO_W + 1;
	localparam int SUM_W = PHI_W + 1;
	localparam int Q_W   = SUM_W - MANT_W;
	localparam int MAG_W = CODE_W - 1;

	localparam logic [LOW_W-1:0] ROUND_BIAS = LOW_W'(3) << 46;
	localparam logic [Q_W-1:0]   CODE_MAX   = Q_W'(32'h7fff_ffff);

	localparam logic [EXP_W-1:0]   LOWEST_EXP_RST = '0;
	localparam logic [SCALE_W-1:0] SCALE_RST      = SCALE_W'(32'h0100_0000);

	typedef struct packed {
		logic [EXP_W-1:0]   lowest_exponent;
		logic [SCALE_W-1:0] scale_factor;
		logic               mixed_signs;
	} cfg_t;

endpackage
`default_nettype wire

>>> rtl/float_fake_log_quantizer.sv
// float_fake_log_quantizer: single-precision word in, fake-log integer code out
// stages: four register stages, s1 to s4, the last of them drives code_valid
// throughput: one request per cycle, set by the fully pipelined 31x31 and 31x24 multipliers
// but a stalled output backs up stage by stage, empty stages keep taking requests
// reset (arst_n, asynchronous, active low) empties the pipeline and restores the registers
`default_nettype none
`include "float_fake_log_quantizer_macros.svh"
module float_fake_log_quantizer
	import ffl_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration port
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	// sample requests
	input  wire logic              value_valid,
	output logic                   value_ready,
	input  wire logic [31:0]       value_bits,
	// code results
	output logic                   code_valid,
	input  wire logic              code_ready,
	output logic signed [CODE_W-1:0] code
);

	cfg_t cfg;

	ffl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// per-stage ready: a stage moves when it is empty or its successor moves
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	assign rdy4        = !v_s4 || code_ready;
	assign rdy3        = !v_s3 || rdy4;
	assign rdy2        = !v_s2 || rdy3;
	assign rdy1        = !v_s1 || rdy2;
	assign value_ready = rdy1;

	// stage 1: split the float, form the fixed-point fake log
	logic [EXP_W-1:0]  in_exp;
	logic [MANT_W-1:0] in_mant;
	logic [EXP_W-1:0]  exp_diff;
	logic              in_below;

	assign in_exp   = value_bits[30:23];
	assign in_mant  = value_bits[22:0];
	assign in_below = in_exp < cfg.lowest_exponent;
	assign exp_diff = in_exp - cfg.lowest_exponent;

	logic [LG_W-1:0] lg_s1;
	logic            below_s1, zero_s1, neg_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= value_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && value_valid) begin
			lg_s1    <= {exp_diff, in_mant};
			below_s1 <= in_below;
			// exponent equal to the lowest and empty mantissa
			zero_s1  <= !in_below && (exp_diff == '0) && (in_mant == '0);
			neg_s1   <= cfg.mixed_signs && value_bits[31];
		end
	end

	// stage 2: two partial products against the split scale
	logic [PHI_W-1:0] phi_s2;
	logic [PLO_W-1:0] plo_s2;
	logic             below_s2, zero_s2, neg_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			phi_s2   <= PHI_W'(lg_s1) * PHI_W'(cfg.scale_factor[SCALE_W-1:SLO_W]);
			plo_s2   <= PLO_W'(lg_s1) * PLO_W'(cfg.scale_factor[SLO_W-1:0]);
			below_s2 <= below_s1;
			zero_s2  <= zero_s1;
			neg_s2   <= neg_s1;
		end
	end

	// stage 3: add the rounding bias and combine the halves
	logic [LOW_W-1:0] low_part;
	logic [SUM_W-1:0] sum;

	assign low_part = {1'b0, plo_s2} + ROUND_BIAS;
	assign sum      = {1'b0, phi_s2} + SUM_W'(low_part[LOW_W-1:SLO_W]);

	logic [Q_W-1:0] q_s3;
	logic           below_s3, zero_s3, neg_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			q_s3     <= sum[SUM_W-1:MANT_W];
			below_s3 <= below_s2;
			zero_s3  <= zero_s2;
			neg_s3   <= neg_s2;
		end
	end

	// stage 4: special cases, saturation, sign; this is the output register
	logic [MAG_W-1:0]  mag;
	logic [CODE_W-1:0] signed_code;

	always_comb begin
		priority if (below_s3) begin
			mag = '0;
		end else if (zero_s3) begin
			mag = MAG_W'(1);
		end else if (q_s3 > CODE_MAX) begin
			mag = CODE_MAX[MAG_W-1:0];
		end else begin
			mag = q_s3[MAG_W-1:0];
		end
	end

	assign signed_code = neg_s3 ? (CODE_W'(0) - {1'b0, mag}) : {1'b0, mag};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (rdy4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			code <= signed'(signed_code);
		end
	end

	assign code_valid = v_s4;

	// an accepted request always lands in stage 1
	`FFL_ASSERT(a_accept_fills_s1, (value_valid && value_ready) |=> v_s1, "request lost at entry")
	// a blocked stage 3 keeps its item
	`FFL_ASSERT(a_s3_holds, (v_s3 && !rdy4) |=> (v_s3 && $stable(q_s3)), "stage 3 dropped item")
	// saturation keeps the code symmetric
	`FFL_ASSERT(a_no_min_code, code_valid |-> (code != signed'(32'h8000_0000)), "code out of range")
	// without mixed signs no code is negative
	`FFL_ASSERT(a_sign_only_mixed, (code_valid && !cfg.mixed_signs) |-> !code[CODE_W-1],
		"negative code in single-sign mode")

endmodule
`default_nettype wire

>>> rtl/ffl_regs.sv
`default_nettype none
module ffl_regs
	import ffl_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	// 8-byte register slots
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lowest_exponent <= LOWEST_EXP_RST;
			cfg_q.scale_factor    <= SCALE_RST;
			cfg_q.mixed_signs     <= 1'b0;
		end else if (wr_en) begin
			unique case (idx)
				REG_LOWEST_EXP: cfg_q.lowest_exponent <= pwdata[EXP_W-1:0];
				REG_SCALE:      cfg_q.scale_factor    <= pwdata[SCALE_W-1:0];
				REG_MIXED:      cfg_q.mixed_signs     <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_LOWEST_EXP: prdata = DATA_W'(cfg_q.lowest_exponent);
			REG_SCALE:      prdata = DATA_W'(cfg_q.scale_factor);
			REG_MIXED:      prdata = DATA_W'(cfg_q.mixed_signs);
			default:        prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

>>> tb/float_fake_log_quantizer_test.sv
`default_nettype none
module float_fake_log_quantizer_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ffl_pkg::*;

	// cycles with no handshake of any kind before the run is declared hung
	localparam int HANG_LIMIT = 4000;
	// settle time after the last code, longer than the pipeline depth
	localparam int SETTLE_CYCLES = 8;
	// random requests per configuration segment, eight segments in all
	localparam int SEG_REQUESTS = 219;

	localparam logic [31:0]        CODE_SAT  = 32'h7fff_ffff;
	localparam logic [SCALE_W-1:0] SCALE_TOP = {SCALE_W{1'b1}};
	localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(64'h100_0000);

	// expected codes, predicted from each accepted sample
	class log_code_board;
		logic [EXP_W-1:0]   lowest_exp;
		logic [SCALE_W-1:0] scale;
		bit                 mixed;
		logic signed [31:0] pending_codes[$];
		int                 mismatches;

		function new();
			lowest_exp  = LOWEST_EXP_RST;
			scale       = SCALE_RST;
			mixed       = 1'b0;
			mismatches  = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [DATA_W-1:0] data);
			case (idx)
				REG_LOWEST_EXP: lowest_exp = data[EXP_W-1:0];
				REG_SCALE:      scale = data[SCALE_W-1:0];
				REG_MIXED:      mixed = data[0];
				default: ;
			endcase
		endfunction

		function logic signed [31:0] predict_code(logic [31:0] bits);
			logic [EXP_W-1:0]  e;
			logic [MANT_W-1:0] m;
			logic [127:0]      lg;
			logic [127:0]      prod;
			logic [31:0]       mag;
			e = bits[30:23];
			m = bits[22:0];
			if (e < lowest_exp) begin
				mag = '0;
			end else begin
				lg = 128'({e - lowest_exp, m});
				if (lg == 0) begin
					mag = 32'd1;
				end else begin
					// exact floor((L*S + 1.5*2^47) / 2^47)
					prod = (lg * 128'(scale) + (128'd3 << 46)) >> 47;
					mag = (prod > 128'(CODE_SAT)) ? CODE_SAT : prod[31:0];
				end
			end
			if (mixed && bits[31])
				mag = -mag;
			return mag;
		endfunction

		function void note_sample(logic [31:0] bits);
			pending_codes.push_back(predict_code(bits));
		endfunction

		task report_mismatch(string what);
			$display("mismatch at %0t: %s", $realtime, what);
			mismatches++;
		endtask

		task check_code(logic signed [31:0] got);
			logic signed [31:0] want;
			if (pending_codes.size() == 0) begin
				report_mismatch($sformatf("code %0d with no sample outstanding", got));
			end else begin
				want = pending_codes.pop_front();
				if (got !== want)
					report_mismatch($sformatf("code %0d, expected %0d", got, want));
			end
		endtask

		function int pending();
			return pending_codes.size();
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [ADDR_W-1:0]       paddr;
	logic [DATA_W-1:0]       pwdata;
	logic [DATA_W-1:0]       prdata;
	logic                    pready;
	logic                    value_valid;
	logic                    value_ready;
	logic [31:0]             value_bits;
	logic                    code_valid;
	logic                    code_ready;
	logic signed [CODE_W-1:0] code;

	log_code_board board;

	// idle percentages of the current phase, and the hang counter
	int send_idle_pct;
	int recv_stall_pct;
	int quiet_cycles;

	float_fake_log_quantizer u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.value_valid(value_valid),
		.value_ready(value_ready),
		.value_bits (value_bits),
		.code_valid (code_valid),
		.code_ready (code_ready),
		.code       (code)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// receiver side: random backpressure at the phase's stall rate
	always @(posedge clk) begin
		code_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// every accepted code is checked against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && code_valid && code_ready)
			board.check_code(code);
	end

	// hang detection: count cycles in which nothing moves on any port
	always @(posedge clk) begin
		if ((value_valid && value_ready) || (code_valid && code_ready) ||
				(psel && penable && pwrite && pready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= HANG_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	// one register write: setup cycle, then access cycle until pready
	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(int'(idx) * 8);
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		board.set_reg(idx, data);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		// idle wait so the next setup never shares a step with the lowering
		@(posedge clk);
	endtask

	task automatic write_config(input logic [EXP_W-1:0] lowest,
			input logic [SCALE_W-1:0] scale, input bit mixed);
		write_reg(REG_LOWEST_EXP, DATA_W'(lowest));
		write_reg(REG_SCALE, DATA_W'(scale));
		write_reg(REG_MIXED, DATA_W'(mixed));
	endtask

	// one sample request; valid stays up into the next request when no gap is drawn
	task automatic push_value(input logic [31:0] bits);
		while ($urandom_range(99) < send_idle_pct) begin
			value_valid <= 1'b0;
			@(posedge clk);
		end
		value_valid <= 1'b1;
		value_bits  <= bits;
		do @(posedge clk); while (!value_ready);
		board.note_sample(bits);
	endtask

	// stop sending and wait for every outstanding code, then let the pipe settle
	task automatic drain();
		value_valid <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// samples weighted toward exponents around the lowest one and odd patterns
	function automatic logic [31:0] rand_sample(input logic [EXP_W-1:0] lowest);
		logic [31:0] bits;
		int          e;
		bits = $urandom;
		case ($urandom_range(9))
			4, 5, 6: begin
				// just below, at, and just above the lowest exponent
				e = int'(lowest) + $urandom_range(10) - 3;
				if (e < 0)
					e = 0;
				if (e > 255)
					e = 255;
				bits[30:23] = 8'(e);
			end
			7: bits[22:0] = $urandom_range(1) ? '1 : '0;
			8: bits[30:23] = $urandom_range(1) ? 8'hff : 8'h00;
			9: bits[30:23] = 8'($urandom_range(255, int'(lowest)));
			default: ;
		endcase
		return bits;
	endfunction

	function automatic logic [SCALE_W-1:0] rand_scale();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		case ($urandom_range(5))
			0: return '0;
			1: return SCALE_TOP;
			2: return SCALE_ONE;
			default: return SCALE_W'(raw) >> $urandom_range(SCALE_W - 1);
		endcase
	endfunction

	function automatic logic [EXP_W-1:0] rand_lowest();
		case ($urandom_range(4))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd127;
			default: return 8'($urandom);
		endcase
	endfunction

	initial begin
		board          = new();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		arst_n      <= 1'b0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		value_valid <= 1'b0;
		value_bits  <= '0;
		code_ready  <= 1'b0;
		quiet_cycles = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: plain magnitudes, sign ignored
		push_value(32'h0000_0000);   // zero fake log
		push_value(32'h8000_0000);   // negative zero, sign ignored
		push_value(32'h0000_0001);
		push_value(32'h007f_ffff);
		push_value(32'h3f80_0000);
		push_value(32'h7f7f_ffff);
		push_value(32'h7f80_0000);   // infinity
		push_value(32'h7fff_ffff);   // nan
		push_value(32'hffff_ffff);   // nan with sign, sign ignored
		drain();

		// mid lowest exponent, full scale, signed codes
		write_config(8'd127, SCALE_TOP, 1'b1);
		push_value(32'h3f80_0000);   // zero fake log
		push_value(32'hbf80_0000);   // negated one
		push_value(32'h3f00_0000);   // below lowest exponent
		push_value(32'hbf00_0000);   // below lowest, negated zero
		push_value(32'h8000_0000);   // negative zero
		push_value(32'h7f80_0000);   // saturates
		push_value(32'hff80_0000);   // saturates, then negated
		push_value(32'hffc0_0000);   // nan with sign bit counts as negative
		drain();

		// top lowest exponent, zero scale
		write_config(8'd255, '0, 1'b1);
		push_value(32'h7f80_0000);   // zero fake log
		push_value(32'h7f80_0001);   // positive fake log with zero scale
		push_value(32'hffff_ffff);
		push_value(32'h0000_0000);
		drain();

		// smallest nonzero scale
		write_config(8'd0, SCALE_W'(1), 1'b0);
		push_value(32'h0000_0001);
		push_value(32'h7fff_ffff);
		drain();

		// random part: four idle phases, two register settings each
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
				default: begin send_idle_pct = 6; recv_stall_pct = 6; end
			endcase
			for (int seg = 0; seg < 2; seg++) begin
				write_config(rand_lowest(), rand_scale(), bit'($urandom_range(1)));
				for (int n = 0; n < SEG_REQUESTS; n++) begin
					// sender holds off once per phase until every code is back
					if (seg == 0 && n == SEG_REQUESTS / 2)
						drain();
					push_value(rand_sample(board.lowest_exp));
				end
				drain();
			end
		end

		if (board.mismatches == 0 && board.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
`default_nettype wire
